/* hdl/ddc_pkg.sv */
// shared types and constants for the decimal digit counter
package ddc_pkg;

    // load value width and number of shift steps in a conversion
    localparam int LOAD_BITS  = 31;
    localparam int BIT_CNT_W  = $clog2(LOAD_BITS);

    // reported result widths
    localparam int OUT_DIGITS = 10;
    localparam int DATA_W     = 4 * OUT_DIGITS;
    localparam int COUNT_W    = 4;
    localparam int REQ_W      = 2;

    // request codes
    typedef logic [REQ_W-1:0] t_req;
    localparam t_req REQ_LOAD = 2'd0;
    localparam t_req REQ_INC  = 2'd1;
    localparam t_req REQ_DEC  = 2'd2;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_FINISH
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic load_start;
        logic shift;
        logic finish;
        logic inc;
        logic dec;
        logic report;
    } t_ddc_cmd;

    // datapath to controller status
    typedef struct packed {
        logic shift_last;
    } t_ddc_sts;

endpackage

/* hdl/decimal_digit_counter_top.sv */
// top level of the decimal digit counter
//
//   channel   direction  handshake          payload
//   request   in         i_valid / o_stall  i_req_type, i_load_value
//   result    out        o_valid / i_stall  o_bcd_digits, o_digit_count, o_wrapped
//
// increment, decrement and unused codes: result valid in the cycle after the request.
// load: a load_start step, 31 shift-add-3 steps over the 31 value bits, then finish.
// one request is in flight at a time; the next is taken once the result register
// is free or being taken in the same cycle.
// synchronous active-low reset: digits zero, count one, no result pending.
// a stalled result holds in the result register; a finished load waits for it.
module decimal_digit_counter_top #(
    parameter int NUM_DIGITS = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [ddc_pkg::REQ_W-1:0]     i_req_type,
    input  logic [ddc_pkg::LOAD_BITS-1:0] i_load_value,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [ddc_pkg::DATA_W-1:0]    o_bcd_digits,
    output logic [ddc_pkg::COUNT_W-1:0]   o_digit_count,
    output logic                          o_wrapped
);
    import ddc_pkg::*;

    t_ddc_cmd cmd;
    t_ddc_sts sts;

    // sequencing
    ddc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_req_type (i_req_type),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // digit store and arithmetic
    ddc_datapath #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_load_value  (i_load_value),
        .o_sts         (sts),
        .o_bcd_digits  (o_bcd_digits),
        .o_digit_count (o_digit_count),
        .o_wrapped     (o_wrapped)
    );

    // a request is never taken while an untaken result would be overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |-> (!o_valid || !i_stall))
        else $error("request taken while result register busy");

    // increment, decrement and report requests answer on the next cycle
    a_fast_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && (i_req_type != REQ_LOAD)) |=> o_valid)
        else $error("increment or decrement result missing");

    // reported count stays within one and the digit count
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_digit_count != '0) && (int'(o_digit_count) <= NUM_DIGITS)))
        else $error("digit count out of range");

    // increment wrap leaves all digits zero
    a_inc_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && (i_req_type == REQ_INC)) ##1 o_wrapped
            |-> (o_bcd_digits == '0))
        else $error("increment wrap left nonzero digits");

endmodule

/* hdl/ddc_datapath.sv */
// digit store, binary to bcd shifter, increment/decrement logic and result register
module ddc_datapath #(
    parameter int NUM_DIGITS = 10
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ddc_pkg::t_ddc_cmd              i_cmd,
    input  logic [ddc_pkg::LOAD_BITS-1:0]  i_load_value,
    output ddc_pkg::t_ddc_sts              o_sts,
    output logic [ddc_pkg::DATA_W-1:0]     o_bcd_digits,
    output logic [ddc_pkg::COUNT_W-1:0]    o_digit_count,
    output logic                           o_wrapped
);
    import ddc_pkg::*;

    localparam int CW   = $clog2(NUM_DIGITS + 1);
    localparam int NOUT = (NUM_DIGITS < OUT_DIGITS) ? NUM_DIGITS : OUT_DIGITS;

    logic [3:0]           r_digit [NUM_DIGITS];
    logic [3:0]           n_digit [NUM_DIGITS];
    logic [CW-1:0]        r_count, n_count;
    logic [LOAD_BITS-1:0] r_bin, n_bin;
    logic [BIT_CNT_W-1:0] r_bit_cnt, n_bit_cnt;
    logic                 n_wrap;
    logic                 capture;

    logic [DATA_W-1:0]    r_out_digits, n_out_digits;
    logic [COUNT_W-1:0]   r_out_count, n_out_count;
    logic                 r_out_wrapped;

    logic                 nine_run [NUM_DIGITS+1];
    logic                 zero_run [NUM_DIGITS+1];
    logic [3:0]           inc_digit [NUM_DIGITS];
    logic [3:0]           dec_digit [NUM_DIGITS];
    logic [3:0]           corr_digit [NUM_DIGITS];
    logic [3:0]           shl_digit [NUM_DIGITS];
    logic [CW-1:0]        inc_count, dec_count, load_count;
    logic                 inc_wrap, dec_wrap;
    logic [7:0]           count_wide;

    // runs of nines and zeros from the least significant digit up
    always_comb begin
        nine_run[0] = 1'b1;
        zero_run[0] = 1'b1;
        for (int k = 0; k < NUM_DIGITS; k++) begin
            nine_run[k+1] = nine_run[k] && (r_digit[k] == 4'd9);
            zero_run[k+1] = zero_run[k] && (r_digit[k] == 4'd0);
        end
    end

    // increment with decimal carry; count grows when the carry passes the top digit
    always_comb begin
        inc_count = CW'(NUM_DIGITS);
        for (int k = 0; k < NUM_DIGITS; k++) begin
            inc_digit[k] = r_digit[k];
            if (nine_run[k]) begin
                if (r_digit[k] == 4'd9) begin
                    inc_digit[k] = 4'd0;
                end else begin
                    inc_digit[k] = r_digit[k] + 4'd1;
                    inc_count    = CW'(k + 1);
                end
            end
        end
        if (!nine_run[r_count]) begin
            inc_count = r_count;
        end
        inc_wrap = nine_run[NUM_DIGITS];
    end

    // decrement with borrow over the significant digits only
    always_comb begin
        dec_count = r_count;
        for (int k = 0; k < NUM_DIGITS; k++) begin
            dec_digit[k] = r_digit[k];
            if ((CW'(k) < r_count) && zero_run[k]) begin
                if (r_digit[k] == 4'd0) begin
                    dec_digit[k] = 4'd9;
                end else begin
                    dec_digit[k] = r_digit[k] - 4'd1;
                    if ((k > 0) && (CW'(k + 1) == r_count) && (r_digit[k] == 4'd1)) begin
                        dec_count = r_count - CW'(1);
                    end
                end
            end
        end
        dec_wrap = zero_run[r_count];
    end

    // one shift-add-3 step of the binary to bcd conversion
    always_comb begin
        for (int k = 0; k < NUM_DIGITS; k++) begin
            corr_digit[k] = (r_digit[k] >= 4'd5) ? (r_digit[k] + 4'd3) : r_digit[k];
        end
        shl_digit[0] = {corr_digit[0][2:0], r_bin[LOAD_BITS-1]};
        for (int k = 1; k < NUM_DIGITS; k++) begin
            shl_digit[k] = {corr_digit[k][2:0], corr_digit[k-1][3]};
        end
    end

    // significant digit count after a conversion, at least one
    always_comb begin
        load_count = CW'(1);
        for (int k = 0; k < NUM_DIGITS; k++) begin
            if (r_digit[k] != 4'd0) begin
                load_count = CW'(k + 1);
            end
        end
    end

    // next state selection by command
    always_comb begin
        n_digit   = r_digit;
        n_count   = r_count;
        n_bin     = r_bin;
        n_bit_cnt = r_bit_cnt;
        n_wrap    = 1'b0;
        priority if (i_cmd.load_start) begin
            for (int k = 0; k < NUM_DIGITS; k++) begin
                n_digit[k] = 4'd0;
            end
            n_bin     = i_load_value;
            n_bit_cnt = '0;
        end else if (i_cmd.shift) begin
            n_digit   = shl_digit;
            n_bin     = {r_bin[LOAD_BITS-2:0], 1'b0};
            n_bit_cnt = r_bit_cnt + BIT_CNT_W'(1);
        end else if (i_cmd.finish) begin
            n_count = load_count;
        end else if (i_cmd.inc) begin
            n_digit = inc_digit;
            n_count = inc_count;
            n_wrap  = inc_wrap;
        end else if (i_cmd.dec) begin
            n_digit = dec_digit;
            n_count = dec_count;
            n_wrap  = dec_wrap;
        end else begin
            n_wrap = 1'b0;
        end
    end

    // result packing from the updated digits
    always_comb begin
        capture      = i_cmd.finish | i_cmd.inc | i_cmd.dec | i_cmd.report;
        n_out_digits = '0;
        for (int k = 0; k < NOUT; k++) begin
            n_out_digits[4*k +: 4] = n_digit[k];
        end
        count_wide  = 8'(n_count);
        n_out_count = (count_wide > 8'd15) ? 4'd15 : count_wide[3:0];
    end

    // digit store and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_DIGITS; k++) begin
                r_digit[k] <= 4'd0;
            end
            r_count <= CW'(1);
        end else begin
            r_digit <= n_digit;
            r_count <= n_count;
        end
    end

    // conversion shifter and step counter
    always_ff @(posedge i_clk) begin
        r_bin     <= n_bin;
        r_bit_cnt <= n_bit_cnt;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (capture) begin
            r_out_digits  <= n_out_digits;
            r_out_count   <= n_out_count;
            r_out_wrapped <= n_wrap;
        end
    end

    assign o_sts.shift_last = (r_bit_cnt == BIT_CNT_W'(LOAD_BITS - 1));
    assign o_bcd_digits     = r_out_digits;
    assign o_digit_count    = r_out_count;
    assign o_wrapped        = r_out_wrapped;

endmodule

/* hdl/ddc_ctrl.sv */
// request sequencing and result valid for the decimal digit counter
module ddc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  ddc_pkg::t_req     i_req_type,
    output logic              o_valid,
    input  logic              i_stall,
    input  ddc_pkg::t_ddc_sts i_sts,
    output ddc_pkg::t_ddc_cmd o_cmd
);
    import ddc_pkg::*;

    t_state   r_state, n_state;
    logic     r_out_valid, n_out_valid;
    logic     out_free;
    logic     in_ready;
    logic     accept;
    logic     capture;
    t_ddc_cmd cmd;

    // result register is free when empty or being taken this cycle
    assign out_free = !r_out_valid || !i_stall;
    assign in_ready = (r_state == ST_IDLE) && out_free;
    assign accept   = i_valid && in_ready;

    // next state and commands
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_req_type)
                        REQ_LOAD: begin
                            cmd.load_start = 1'b1;
                            n_state        = ST_SHIFT;
                        end
                        REQ_INC: cmd.inc = 1'b1;
                        REQ_DEC: cmd.dec = 1'b1;
                        default: cmd.report = 1'b1;
                    endcase
                end
            end
            ST_SHIFT: begin
                cmd.shift = 1'b1;
                if (i_sts.shift_last) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    cmd.finish = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // result valid tracking
    always_comb begin
        capture = cmd.inc | cmd.dec | cmd.report | cmd.finish;
        priority if (capture) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // state and valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = !in_ready;
    assign o_valid = r_out_valid;
    assign o_cmd   = cmd;

endmodule
